// ===== design/sdspi_pkg.sv =====
// Shared types and constants for the SD SPI command sequencer.
package sdspi_pkg;

    localparam int unsigned READY_LIMIT_W = 16;
    localparam int unsigned RESP_LIMIT_W  = 8;
    localparam int unsigned CFG_DATA_W    = 16;
    localparam int unsigned POLL_W        = 16;

    localparam logic [READY_LIMIT_W-1:0] READY_LIMIT_RST = 16'd50000;
    localparam logic [RESP_LIMIT_W-1:0]  RESP_LIMIT_RST  = 8'd255;

    // configuration register indexes
    localparam logic CFG_READY_LIMIT = 1'b0;
    localparam logic CFG_RESP_LIMIT  = 1'b1;

    // request kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_BYTE  = 1'b1;

    // command indexes with special handling
    localparam logic [5:0] CMD_GO_IDLE = 6'd0;
    localparam logic [5:0] CMD_IF_COND = 6'd8;
    localparam logic [5:0] CMD_STOP    = 6'd12;
    localparam logic [5:0] CMD_APP     = 6'd55;

    localparam logic [7:0] BYTE_IDLE    = 8'hFF;
    localparam logic [7:0] FRAME_START  = 8'h40;
    localparam logic [7:0] CRC_GO_IDLE  = 8'h95;
    localparam logic [7:0] CRC_IF_COND  = 8'h87;
    localparam logic [7:0] CRC_DEFAULT  = 8'h01;
    localparam logic [2:0] FRAME_BYTES  = 3'd6;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_DESEL,
        PH_SEL,
        PH_READY,
        PH_TOUT,
        PH_FRAME,
        PH_DISCARD,
        PH_RESP
    } phase_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       chip_select;
        logic       done_res;
        logic [7:0] response;
    } result_t;

endpackage

// ===== design/sdspi_if.sv =====
// Request and result channel interfaces for the SD SPI command sequencer.
interface sdspi_cmd_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [5:0]  command_index;
    logic        app_command;
    logic [31:0] argument;
    logic [7:0]  rx_byte;

    modport source (output valid, kind, command_index, app_command, argument, rx_byte,
                    input ready);
    modport sink   (input valid, kind, command_index, app_command, argument, rx_byte,
                    output ready);
endinterface

interface sdspi_rsp_if;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       chip_select;
    logic       done_res;
    logic [7:0] response;

    modport source (output valid, tx_valid, tx_byte, chip_select, done_res, response,
                    input ready);
    modport sink   (input valid, tx_valid, tx_byte, chip_select, done_res, response,
                    output ready);
endinterface

// ===== design/sd_spi_command_engine.sv =====
// SD card SPI-mode command sequencer, top level.
// The result of an accepted request is registered in the output register.
// One request per cycle unless the output stalls; the FSM steps once per request.
// A request is taken while the held result is being collected in the same cycle.
// Reset (rst_n low, asynchronous): idle, card deselected, output empty,
// ready poll limit 50000, response poll limit 255.
module sd_spi_command_engine (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic                             cfg_index,
    input  logic [sdspi_pkg::CFG_DATA_W-1:0] cfg_data,
    sdspi_cmd_if.sink                        cmd,
    sdspi_rsp_if.source                      rsp
);

    logic               free;
    logic               accept;
    sdspi_pkg::result_t result;

    assign cmd.ready = free;
    assign accept    = cmd.valid && free;

    sdspi_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .step          (accept),
        .kind          (cmd.kind),
        .command_index (cmd.command_index),
        .app_command   (cmd.app_command),
        .argument      (cmd.argument),
        .rx_byte       (cmd.rx_byte),
        .result        (result)
    );

    sdspi_out_reg u_out_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept),
        .result (result),
        .free   (free),
        .rsp    (rsp)
    );

endmodule

// ===== design/sdspi_core.sv =====
// Command sequencer state machine: one step per accepted request.
module sdspi_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic                                   cfg_index,
    input  logic [sdspi_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                   step,
    input  logic                                   kind,
    input  logic [5:0]                             command_index,
    input  logic                                   app_command,
    input  logic [31:0]                            argument,
    input  logic [7:0]                             rx_byte,
    output sdspi_pkg::result_t                     result
);

    logic [sdspi_pkg::READY_LIMIT_W-1:0] ready_limit_reg;
    logic [sdspi_pkg::RESP_LIMIT_W-1:0]  resp_limit_reg;

    sdspi_pkg::phase_t           phase_reg, phase_next;
    logic [2:0]                  byte_count_reg, byte_count_next;
    logic [sdspi_pkg::POLL_W-1:0] poll_count_reg, poll_count_next;
    logic [5:0]                  active_index_reg, active_index_next;
    logic [5:0]                  main_index_reg, main_index_next;
    logic                        main_pending_reg, main_pending_next;
    logic [31:0]                 argument_hold_reg, argument_hold_next;
    logic                        select_reg, select_next;

    function automatic logic [7:0] frame_byte(input logic [2:0] k, input logic [5:0] idx,
                                              input logic [31:0] arg_in, input logic pend);
        logic [31:0] arg;
        logic [7:0]  b;
        arg = pend ? 32'd0 : arg_in;
        case (k)
            3'd0: b = sdspi_pkg::FRAME_START | {2'b00, idx};
            3'd1: b = arg[31:24];
            3'd2: b = arg[23:16];
            3'd3: b = arg[15:8];
            3'd4: b = arg[7:0];
            default:
            begin
                if (idx == sdspi_pkg::CMD_GO_IDLE)
                    b = sdspi_pkg::CRC_GO_IDLE;
                else if (idx == sdspi_pkg::CMD_IF_COND)
                    b = sdspi_pkg::CRC_IF_COND;
                else
                    b = sdspi_pkg::CRC_DEFAULT;
            end
        endcase
        return b;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_limit_reg <= sdspi_pkg::READY_LIMIT_RST;
            resp_limit_reg  <= sdspi_pkg::RESP_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == sdspi_pkg::CFG_READY_LIMIT)
                ready_limit_reg <= cfg_data[sdspi_pkg::READY_LIMIT_W-1:0];
            else
                resp_limit_reg <= cfg_data[sdspi_pkg::RESP_LIMIT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= sdspi_pkg::PH_IDLE;
            byte_count_reg    <= '0;
            poll_count_reg    <= '0;
            active_index_reg  <= '0;
            main_index_reg    <= '0;
            main_pending_reg  <= 1'b0;
            argument_hold_reg <= '0;
            select_reg        <= 1'b0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            byte_count_reg    <= byte_count_next;
            poll_count_reg    <= poll_count_next;
            active_index_reg  <= active_index_next;
            main_index_reg    <= main_index_next;
            main_pending_reg  <= main_pending_next;
            argument_hold_reg <= argument_hold_next;
            select_reg        <= select_next;
        end
    end

    always_comb
    begin
        logic                         do_begin;
        logic [5:0]                   begin_idx;
        logic                         do_finish;
        logic [7:0]                   fin_res;
        logic [2:0]                   bc_inc;
        logic [sdspi_pkg::POLL_W-1:0] pc_dec;
        logic                         tx_v;
        logic [7:0]                   tx_b;
        logic                         done;
        logic [7:0]                   resp;

        phase_next         = phase_reg;
        byte_count_next    = byte_count_reg;
        poll_count_next    = poll_count_reg;
        active_index_next  = active_index_reg;
        main_index_next    = main_index_reg;
        main_pending_next  = main_pending_reg;
        argument_hold_next = argument_hold_reg;
        select_next        = select_reg;

        do_begin  = 1'b0;
        begin_idx = '0;
        do_finish = 1'b0;
        fin_res   = '0;
        tx_v      = 1'b0;
        tx_b      = '0;
        done      = 1'b0;
        resp      = '0;
        bc_inc    = byte_count_reg + 3'd1;
        pc_dec    = (poll_count_reg != '0) ? poll_count_reg - 1'b1 : poll_count_reg;

        if (kind == sdspi_pkg::KIND_START)
        begin
            main_index_next    = command_index;
            main_pending_next  = app_command;
            argument_hold_next = argument;
            do_begin           = 1'b1;
            begin_idx          = app_command ? sdspi_pkg::CMD_APP : command_index;
        end
        else
        begin
            unique case (phase_reg)
                sdspi_pkg::PH_DESEL:
                begin
                    select_next = 1'b1;
                    phase_next  = sdspi_pkg::PH_SEL;
                    tx_v        = 1'b1;
                    tx_b        = sdspi_pkg::BYTE_IDLE;
                end
                sdspi_pkg::PH_SEL:
                begin
                    phase_next      = sdspi_pkg::PH_READY;
                    poll_count_next = ready_limit_reg;
                    tx_v            = 1'b1;
                    tx_b            = sdspi_pkg::BYTE_IDLE;
                end
                sdspi_pkg::PH_READY:
                begin
                    tx_v = 1'b1;
                    if (rx_byte == sdspi_pkg::BYTE_IDLE)
                    begin
                        phase_next      = sdspi_pkg::PH_FRAME;
                        byte_count_next = '0;
                        tx_b            = frame_byte(3'd0, active_index_reg,
                                                     argument_hold_reg, main_pending_reg);
                    end
                    else if (poll_count_reg != '0)
                    begin
                        poll_count_next = pc_dec;
                        tx_b            = sdspi_pkg::BYTE_IDLE;
                    end
                    else
                    begin
                        select_next = 1'b0;
                        phase_next  = sdspi_pkg::PH_TOUT;
                        tx_b        = sdspi_pkg::BYTE_IDLE;
                    end
                end
                sdspi_pkg::PH_TOUT:
                begin
                    do_finish = 1'b1;
                    fin_res   = sdspi_pkg::BYTE_IDLE;
                end
                sdspi_pkg::PH_FRAME:
                begin
                    byte_count_next = bc_inc;
                    tx_v            = 1'b1;
                    if (bc_inc < sdspi_pkg::FRAME_BYTES)
                        tx_b = frame_byte(bc_inc, active_index_reg,
                                          argument_hold_reg, main_pending_reg);
                    else if (active_index_reg == sdspi_pkg::CMD_STOP)
                    begin
                        phase_next = sdspi_pkg::PH_DISCARD;
                        tx_b       = sdspi_pkg::BYTE_IDLE;
                    end
                    else
                    begin
                        // zero limit counts as 256 polls
                        phase_next      = sdspi_pkg::PH_RESP;
                        poll_count_next = (resp_limit_reg != '0)
                                        ? sdspi_pkg::POLL_W'(resp_limit_reg)
                                        : sdspi_pkg::POLL_W'(256);
                        tx_b            = sdspi_pkg::BYTE_IDLE;
                    end
                end
                sdspi_pkg::PH_DISCARD:
                begin
                    phase_next      = sdspi_pkg::PH_RESP;
                    poll_count_next = (resp_limit_reg != '0)
                                    ? sdspi_pkg::POLL_W'(resp_limit_reg)
                                    : sdspi_pkg::POLL_W'(256);
                    tx_v            = 1'b1;
                    tx_b            = sdspi_pkg::BYTE_IDLE;
                end
                sdspi_pkg::PH_RESP:
                begin
                    poll_count_next = pc_dec;
                    if (rx_byte[7] && (pc_dec != '0))
                    begin
                        tx_v = 1'b1;
                        tx_b = sdspi_pkg::BYTE_IDLE;
                    end
                    else
                    begin
                        do_finish = 1'b1;
                        fin_res   = rx_byte;
                    end
                end
                default:
                begin
                    tx_v = 1'b0;
                end
            endcase
        end

        // CMD55 answered 0 or 1: go on with the main command
        if (do_finish)
        begin
            main_pending_next = 1'b0;
            if (main_pending_reg && (fin_res <= 8'd1))
            begin
                do_begin  = 1'b1;
                begin_idx = main_index_reg;
            end
            else
            begin
                phase_next = sdspi_pkg::PH_IDLE;
                done       = 1'b1;
                resp       = fin_res;
            end
        end

        if (do_begin)
        begin
            active_index_next = begin_idx;
            tx_v              = 1'b1;
            if (begin_idx == sdspi_pkg::CMD_STOP)
            begin
                phase_next      = sdspi_pkg::PH_FRAME;
                byte_count_next = '0;
                tx_b            = sdspi_pkg::FRAME_START | {2'b00, begin_idx};
            end
            else
            begin
                phase_next  = sdspi_pkg::PH_DESEL;
                select_next = 1'b0;
                tx_b        = sdspi_pkg::BYTE_IDLE;
            end
        end

        result.tx_valid    = tx_v;
        result.tx_byte     = tx_b;
        result.chip_select = select_next;
        result.done_res    = done;
        result.response    = resp;
    end

endmodule

// ===== design/sdspi_out_reg.sv =====
// Result register driving the result channel.
module sdspi_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  sdspi_pkg::result_t result,
    output logic               free,
    sdspi_rsp_if.source        rsp
);

    logic               valid_reg;
    sdspi_pkg::result_t data_reg;

    assign free = !valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (free)
            valid_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result;
    end

    assign rsp.valid       = valid_reg;
    assign rsp.tx_valid    = data_reg.tx_valid;
    assign rsp.tx_byte     = data_reg.tx_byte;
    assign rsp.chip_select = data_reg.chip_select;
    assign rsp.done_res    = data_reg.done_res;
    assign rsp.response    = data_reg.response;

endmodule

// ===== test/tb_sd_spi_command_engine.sv =====
// Self-checking bench for the SD SPI command sequencer: predicts every SPI exchange and checks it.
module tb_sd_spi_command_engine;
    import sdspi_pkg::*;

    localparam int HOLD_OFF_CYCLES = 200;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    sdspi_cmd_if cmd();
    sdspi_rsp_if rsp();

    sd_spi_command_engine i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .rsp       (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predicted sequencer state and register copies
    phase_t      seq_phase      = PH_IDLE;
    logic [2:0]  frame_pos      = '0;
    logic [16:0] polls_left     = '0;
    logic [5:0]  live_index     = '0;
    logic [5:0]  queued_index   = '0;
    logic        queued_pending = 1'b0;
    logic [31:0] held_argument  = '0;
    logic        card_selected  = 1'b0;
    logic [15:0] ready_limit    = READY_LIMIT_RST;
    logic [7:0]  resp_limit     = RESP_LIMIT_RST;

    result_t expected_exchanges[$];
    int      failures      = 0;
    int      requests_sent = 0;
    int      burst_left    = 0;
    bit      sender_gaps   = 1'b0;
    bit      stall_mode    = 1'b0;
    bit      hold_off_req  = 1'b0;

    function automatic result_t exchange(logic v, logic [7:0] tx, logic d, logic [7:0] r);
        result_t o;
        o.tx_valid    = v;
        o.tx_byte     = v ? tx : 8'h00;
        o.chip_select = card_selected;
        o.done_res    = d;
        o.response    = d ? r : 8'h00;
        return o;
    endfunction

    function automatic logic [7:0] frame_octet(logic [2:0] k);
        logic [31:0] a;
        a = queued_pending ? 32'h0 : held_argument;
        case (k)
            3'd0: return FRAME_START | {2'b00, live_index};
            3'd1: return a[31:24];
            3'd2: return a[23:16];
            3'd3: return a[15:8];
            3'd4: return a[7:0];
            default:
            begin
                if (live_index == CMD_GO_IDLE) return CRC_GO_IDLE;
                if (live_index == CMD_IF_COND) return CRC_IF_COND;
                return CRC_DEFAULT;
            end
        endcase
    endfunction

    // CMD12 goes straight to the frame and keeps the select level
    function automatic result_t open_command();
        if (live_index == CMD_STOP)
        begin
            seq_phase = PH_FRAME;
            frame_pos = '0;
            return exchange(1'b1, frame_octet(3'd0), 1'b0, 8'h00);
        end
        seq_phase     = PH_DESEL;
        card_selected = 1'b0;
        return exchange(1'b1, BYTE_IDLE, 1'b0, 8'h00);
    endfunction

    function automatic result_t open_response_poll();
        seq_phase  = PH_RESP;
        polls_left = (resp_limit != 8'h00) ? {9'd0, resp_limit} : 17'd256;
        return exchange(1'b1, BYTE_IDLE, 1'b0, 8'h00);
    endfunction

    function automatic result_t close_command(logic [7:0] res);
        if (queued_pending && res <= 8'd1)
        begin
            queued_pending = 1'b0;
            live_index     = queued_index;
            return open_command();
        end
        queued_pending = 1'b0;
        seq_phase      = PH_IDLE;
        return exchange(1'b0, 8'h00, 1'b1, res);
    endfunction

    function automatic result_t next_exchange(logic kind, logic [5:0] idx, logic app,
                                              logic [31:0] arg, logic [7:0] rx);
        if (kind == KIND_START)
        begin
            queued_index   = idx;
            queued_pending = app;
            held_argument  = arg;
            live_index     = app ? CMD_APP : idx;
            return open_command();
        end
        case (seq_phase)
            PH_DESEL:
            begin
                card_selected = 1'b1;
                seq_phase     = PH_SEL;
                return exchange(1'b1, BYTE_IDLE, 1'b0, 8'h00);
            end
            PH_SEL:
            begin
                seq_phase  = PH_READY;
                polls_left = {1'b0, ready_limit};
                return exchange(1'b1, BYTE_IDLE, 1'b0, 8'h00);
            end
            PH_READY:
            begin
                if (rx == BYTE_IDLE)
                begin
                    seq_phase = PH_FRAME;
                    frame_pos = '0;
                    return exchange(1'b1, frame_octet(3'd0), 1'b0, 8'h00);
                end
                if (polls_left != 0)
                begin
                    polls_left--;
                    return exchange(1'b1, BYTE_IDLE, 1'b0, 8'h00);
                end
                card_selected = 1'b0;
                seq_phase     = PH_TOUT;
                return exchange(1'b1, BYTE_IDLE, 1'b0, 8'h00);
            end
            PH_TOUT: return close_command(BYTE_IDLE);
            PH_FRAME:
            begin
                frame_pos = frame_pos + 3'd1;
                if (frame_pos < FRAME_BYTES)
                    return exchange(1'b1, frame_octet(frame_pos), 1'b0, 8'h00);
                if (live_index == CMD_STOP)
                begin
                    seq_phase = PH_DISCARD;
                    return exchange(1'b1, BYTE_IDLE, 1'b0, 8'h00);
                end
                return open_response_poll();
            end
            PH_DISCARD: return open_response_poll();
            PH_RESP:
            begin
                if (polls_left > 0) polls_left--;
                if (rx[7] && polls_left != 0)
                    return exchange(1'b1, BYTE_IDLE, 1'b0, 8'h00);
                return close_command(rx);
            end
            default: return exchange(1'b0, 8'h00, 1'b0, 8'h00);
        endcase
    endfunction

    // what the card answers, given where the sequence stands
    function automatic logic [7:0] card_reply(int ready_pct, int r1_pct, int r1_value);
        case (seq_phase)
            PH_READY:
            begin
                if ($urandom_range(1, 100) <= ready_pct) return BYTE_IDLE;
                return 8'($urandom_range(0, 254));
            end
            PH_RESP:
            begin
                if ($urandom_range(1, 100) > r1_pct) return 8'h80 | 8'($urandom_range(0, 127));
                if (r1_value >= 0) return 8'(r1_value);
                if ($urandom_range(0, 2) == 0) return 8'($urandom_range(0, 127));
                return 8'($urandom_range(0, 1));
            end
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [5:0] pick_index();
        case ($urandom_range(0, 7))
            0: return CMD_GO_IDLE;
            1: return CMD_IF_COND;
            2: return CMD_STOP;
            3: return CMD_APP;
            default: return 6'($urandom_range(0, 63));
        endcase
    endfunction

    function automatic logic [31:0] pick_argument();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic void check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch: expected %02h, actual %02h", $time, name, want_v, got_v);
            failures++;
        end
    endfunction

    task automatic send_request(logic kind, logic [5:0] idx, logic app, logic [31:0] arg,
                                logic [7:0] rx);
        logic ignored;
        if (sender_gaps && burst_left == 0)
        begin
            cmd.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;
        cmd.valid         <= 1'b1;
        cmd.kind          <= kind;
        cmd.command_index <= idx;
        cmd.app_command   <= app;
        cmd.argument      <= arg;
        cmd.rx_byte       <= rx;
        do @(posedge clk); while (!cmd.ready);
        ignored = (kind == KIND_BYTE) && (seq_phase == PH_IDLE);
        expected_exchanges.push_back(next_exchange(kind, idx, app, arg, rx));
        if (!ignored) requests_sent++;
    endtask

    task automatic wait_for_drain();
        cmd.valid <= 1'b0;
        do @(posedge clk); while (expected_exchanges.size() != 0);
    endtask

    // max_bytes < 0 runs the command to completion; otherwise at most max_bytes bytes follow
    task automatic run_command(logic [5:0] idx, logic app, logic [31:0] arg, int ready_pct,
                               int r1_pct, int r1_value, int max_bytes);
        int sent;
        sent = 0;
        send_request(KIND_START, idx, app, arg, 8'($urandom));
        while (seq_phase != PH_IDLE && (max_bytes < 0 || sent < max_bytes))
        begin
            send_request(KIND_BYTE, 6'($urandom), 1'($urandom), $urandom,
                         card_reply(ready_pct, r1_pct, r1_value));
            sent++;
        end
    endtask

    task automatic settle_block();
        while (seq_phase != PH_IDLE)
            send_request(KIND_BYTE, 6'h00, 1'b0, 32'h0, card_reply(100, 100, -1));
        wait_for_drain();
    endtask

    task automatic write_register(logic idx, logic [15:0] data);
        settle_block();
        repeat (2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_READY_LIMIT)
            ready_limit = data;
        else
            resp_limit = data[7:0];
        @(posedge clk);
    endtask

    task automatic test_idle_bytes();
        send_request(KIND_BYTE, 6'h00, 1'b0, 32'h0, 8'h00);
        send_request(KIND_BYTE, 6'h3F, 1'b1, 32'hFFFF_FFFF, 8'hFF);
        // stop command from reset: card never selected
        run_command(CMD_STOP, 1'b0, 32'h0, 100, 100, -1, -1);
    endtask

    task automatic test_frames();
        run_command(CMD_GO_IDLE, 1'b0, 32'h0000_0000, 100, 100, 1, -1);
        run_command(CMD_IF_COND, 1'b0, 32'hFFFF_FFFF, 100, 100, 1, -1);
        run_command(6'd63, 1'b0, 32'hA5C3_0F5A, 50, 50, 0, -1);
        run_command(CMD_STOP, 1'b0, 32'h5A3C_F0A5, 100, 100, 0, -1);
    endtask

    task automatic test_app_command();
        // CMD55 rejected: stops there
        run_command(6'd41, 1'b1, 32'h4000_0000, 100, 100, 5, -1);
        run_command(6'd41, 1'b1, 32'h4000_0000, 100, 100, 1, -1);
        run_command(CMD_STOP, 1'b1, 32'h1234_5678, 100, 100, 0, -1);
    endtask

    task automatic test_ready_timeout();
        write_register(CFG_READY_LIMIT, 16'd0);
        run_command(6'd17, 1'b0, $urandom, 0, 100, -1, -1);
        write_register(CFG_READY_LIMIT, 16'd3);
        run_command(6'd24, 1'b1, $urandom, 0, 100, -1, -1);
        write_register(CFG_READY_LIMIT, 16'hFFFF);
        run_command(6'd9, 1'b0, $urandom, 50, 100, -1, -1);
    endtask

    task automatic test_response_limits();
        // zero wraps to 256 polls
        write_register(CFG_RESP_LIMIT, 16'hA500);
        run_command(6'd13, 1'b0, $urandom, 100, 0, -1, -1);
        write_register(CFG_RESP_LIMIT, 16'h5A01);
        run_command(6'd16, 1'b0, $urandom, 100, 0, -1, -1);
        write_register(CFG_RESP_LIMIT, 16'h3C02);
        run_command(6'd58, 1'b0, $urandom, 100, 0, -1, -1);
    endtask

    task automatic test_abort();
        // new start at each point of a running command
        sender_gaps = 1'b1;
        stall_mode  = 1'b1;
        for (int k = 0; k < 14; k++)
            run_command(pick_index(), 1'($urandom), pick_argument(), 60, 60, -1, k);
        run_command(pick_index(), 1'b0, pick_argument(), 100, 100, -1, -1);
    endtask

    task automatic test_backpressure();
        sender_gaps  = 1'b0;
        stall_mode   = 1'b0;
        hold_off_req = 1'b1;
        run_command(CMD_IF_COND, 1'b1, 32'h0000_01AA, 70, 70, -1, -1);
        run_command(pick_index(), 1'b0, pick_argument(), 70, 70, -1, -1);
        wait_for_drain();
    endtask

    task automatic test_random();
        int          target;
        int          cmds;
        int          pick;
        int          ready_pct;
        logic [7:0]  r1_lim;
        logic [15:0] lim;
        target = 950;
        cmds   = 0;
        while (requests_sent < target)
        begin
            sender_gaps = ($urandom_range(0, 3) != 0);
            stall_mode  = ($urandom_range(0, 3) != 0);
            cmds++;
            if (cmds % 20 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: lim = 16'($urandom_range(0, 3));
                    1: lim = 16'hFFFF;
                    2: lim = 16'($urandom);
                    default: lim = 16'($urandom_range(0, 16));
                endcase
                write_register(CFG_READY_LIMIT, lim);
                if ($urandom_range(0, 3) == 0)
                    r1_lim = 8'($urandom_range(0, 3));
                else
                    r1_lim = 8'($urandom);
                write_register(CFG_RESP_LIMIT, {8'($urandom), r1_lim});
            end
            pick      = $urandom_range(0, 99);
            ready_pct = (ready_limit > 16) ? $urandom_range(20, 100) : $urandom_range(0, 100);
            if (pick < 75)
                run_command(pick_index(), 1'($urandom), pick_argument(), ready_pct,
                            $urandom_range(10, 100), -1, -1);
            else if (pick < 88)
                run_command(pick_index(), 1'($urandom), pick_argument(), ready_pct,
                            $urandom_range(10, 100), -1, $urandom_range(0, 12));
            else if (pick < 96)
                repeat ($urandom_range(1, 4))
                    send_request(1'($urandom), 6'($urandom), 1'($urandom), pick_argument(),
                                 8'($urandom));
            else
                wait_for_drain();
        end
    endtask

    // receiver side: own stall pattern, plus one long hold-off on request
    initial
    begin
        logic [15:0] pattern;
        int          held;
        rsp.ready <= 1'b0;
        pattern = 16'hFFFF;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                rsp.ready <= 1'b0;
                for (held = 0; held < HOLD_OFF_CYCLES; held++) @(posedge clk);
            end
            else if (!stall_mode)
                rsp.ready <= 1'b1;
            else
            begin
                rsp.ready <= pattern[0];
                pattern = {pattern[0], pattern[15:1]};
                if ($urandom_range(0, 15) == 0)
                    pattern = 16'($urandom) | 16'h0101;
            end
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_exchanges.size() == 0)
            begin
                $display("%0t: result with nothing expected: tx_valid=%0b tx_byte=%02h cs=%0b",
                         $time, rsp.tx_valid, rsp.tx_byte, rsp.chip_select);
                failures++;
            end
            else
            begin
                want = expected_exchanges.pop_front();
                check_field("tx_valid", 8'(want.tx_valid), 8'(rsp.tx_valid));
                check_field("tx_byte", want.tx_byte, rsp.tx_byte);
                check_field("chip_select", 8'(want.chip_select), 8'(rsp.chip_select));
                check_field("done_res", 8'(want.done_res), 8'(rsp.done_res));
                check_field("response", want.response, rsp.response);
            end
        end
    end

    initial
    begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_READY_LIMIT;
        cfg_data          <= '0;
        cmd.valid         <= 1'b0;
        cmd.kind          <= KIND_START;
        cmd.command_index <= '0;
        cmd.app_command   <= 1'b0;
        cmd.argument      <= '0;
        cmd.rx_byte       <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_idle_bytes();
        test_frames();
        test_app_command();
        test_ready_timeout();
        test_response_limits();
        test_abort();
        test_backpressure();
        test_random();

        wait_for_drain();
        repeat (4) @(posedge clk);
        if (failures == 0 && expected_exchanges.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sd_spi_command_engine.f =====
design/sdspi_pkg.sv
design/sdspi_if.sv
design/sdspi_core.sv
design/sdspi_out_reg.sv
design/sd_spi_command_engine.sv
test/tb_sd_spi_command_engine.sv
